/* sv/hspos_pkg.sv */
// Package for the half-step stepper positioner.
// Holds default sizes, register indexes, reset values and the coil table.
// No dependencies.
package hspos_pkg;

  localparam int NUM_MOTORS_DEF    = 3;
  localparam int POSITION_BITS_DEF = 10;
  localparam int MOTOR_W           = 2;
  localparam int PHASE_W           = 3;
  localparam int COIL_W            = 4;
  localparam int CFG_IDX_W         = 3;

  localparam int OPEN_CODE_RST     = 1021;
  localparam int CLOSE_CODE_RST    = 1022;
  localparam int BUSY_CODE_RST     = 1023;
  localparam int FULL_TRAVEL_RST   = 360;
  localparam int SHORT_TRAVEL_RST  = 90;
  localparam logic [MOTOR_W-1:0] SHORT_MOTOR_RST = 2'd2;
  localparam logic CCW_VALUE_RST   = 1'b1;
  localparam logic RUN_ENABLE_RST  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPEN_CODE    = 3'd0,
    CFG_CLOSE_CODE   = 3'd1,
    CFG_BUSY_CODE    = 3'd2,
    CFG_FULL_TRAVEL  = 3'd3,
    CFG_SHORT_TRAVEL = 3'd4,
    CFG_SHORT_MOTOR  = 3'd5,
    CFG_CCW_VALUE    = 3'd6,
    CFG_RUN_ENABLE   = 3'd7
  } cfg_reg_e;

  function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] coil;
    case (phase)
      3'd0:    coil = 4'h1;
      3'd1:    coil = 4'h3;
      3'd2:    coil = 4'h2;
      3'd3:    coil = 4'h6;
      3'd4:    coil = 4'h4;
      3'd5:    coil = 4'hC;
      3'd6:    coil = 4'h8;
      default: coil = 4'h9;
    endcase
    return coil;
  endfunction

endpackage

/* sv/hspos_in_if.sv */
// Request channel of the stepper positioner: one tick for one motor.
// Depends on hspos_pkg.
interface hspos_in_if #(
  parameter int POSITION_BITS = hspos_pkg::POSITION_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [hspos_pkg::MOTOR_W-1:0]    motor_index;
  logic [POSITION_BITS-1:0]         required_position;

  modport source (output valid, output motor_index, output required_position, input ready);
  modport sink   (input valid, input motor_index, input required_position, output ready);
endinterface

/* sv/hspos_out_if.sv */
// Result channel of the stepper positioner: coil pattern and motor status.
// Depends on hspos_pkg.
interface hspos_out_if #(
  parameter int POSITION_BITS = hspos_pkg::POSITION_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [hspos_pkg::MOTOR_W-1:0]    motor_served;
  logic [hspos_pkg::COIL_W-1:0]     coil_pattern;
  logic                             coils_updated;
  logic [POSITION_BITS-1:0]         reported_position;

  modport source (output valid, output motor_served, output coil_pattern,
                  output coils_updated, output reported_position, input ready);
  modport sink   (input valid, input motor_served, input coil_pattern,
                  input coils_updated, input reported_position, output ready);
endinterface

/* sv/hspos_core.sv */
// Configuration registers, per-motor state and the combinational tick update.
// Depends on hspos_pkg.
module hspos_core #(
  parameter int NUM_MOTORS    = hspos_pkg::NUM_MOTORS_DEF,
  parameter int POSITION_BITS = hspos_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hspos_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [POSITION_BITS-1:0]          cfg_data_i,
  input  logic                              fire_i,
  input  logic [hspos_pkg::MOTOR_W-1:0]     motor_i,
  input  logic [POSITION_BITS-1:0]          required_i,
  output logic [hspos_pkg::COIL_W-1:0]      coil_o,
  output logic                              updated_o,
  output logic [POSITION_BITS-1:0]          status_o
);

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int PW    = hspos_pkg::PHASE_W;

  logic [POSITION_BITS-1:0]       open_q, close_q, busy_q, full_q, short_q;
  logic [hspos_pkg::MOTOR_W-1:0]  short_motor_q;
  logic                           ccw_q, run_q;

  logic [PW-1:0]                  phase_q  [NUM_MOTORS];
  logic [POSITION_BITS-1:0]       cycles_q [NUM_MOTORS];
  logic                           dir_q    [NUM_MOTORS];
  logic [POSITION_BITS-1:0]       goal_q   [NUM_MOTORS];
  logic [POSITION_BITS-1:0]       status_q [NUM_MOTORS];

  logic [IDX_W-1:0]               idx;
  logic                           in_range, act, start, moving, fixed_code;
  logic [PW-1:0]                  cur_phase, phase_d, phase_res;
  logic [POSITION_BITS-1:0]       cur_cycles, cur_goal, cur_status;
  logic                           cur_dir, dir_d;
  logic [POSITION_BITS-1:0]       start_cnt, step_cnt, cycles_d, goal_d, status_d;
  logic                           start_dir;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q        <= POSITION_BITS'(hspos_pkg::OPEN_CODE_RST);
      close_q       <= POSITION_BITS'(hspos_pkg::CLOSE_CODE_RST);
      busy_q        <= POSITION_BITS'(hspos_pkg::BUSY_CODE_RST);
      full_q        <= POSITION_BITS'(hspos_pkg::FULL_TRAVEL_RST);
      short_q       <= POSITION_BITS'(hspos_pkg::SHORT_TRAVEL_RST);
      short_motor_q <= hspos_pkg::SHORT_MOTOR_RST;
      ccw_q         <= hspos_pkg::CCW_VALUE_RST;
      run_q         <= hspos_pkg::RUN_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (hspos_pkg::cfg_reg_e'(cfg_index_i))
        hspos_pkg::CFG_OPEN_CODE:    open_q        <= cfg_data_i;
        hspos_pkg::CFG_CLOSE_CODE:   close_q       <= cfg_data_i;
        hspos_pkg::CFG_BUSY_CODE:    busy_q        <= cfg_data_i;
        hspos_pkg::CFG_FULL_TRAVEL:  full_q        <= cfg_data_i;
        hspos_pkg::CFG_SHORT_TRAVEL: short_q       <= cfg_data_i;
        hspos_pkg::CFG_SHORT_MOTOR:  short_motor_q <= cfg_data_i[hspos_pkg::MOTOR_W-1:0];
        hspos_pkg::CFG_CCW_VALUE:    ccw_q         <= cfg_data_i[0];
        hspos_pkg::CFG_RUN_ENABLE:   run_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    idx        = IDX_W'(motor_i);
    in_range   = (int'(motor_i) < NUM_MOTORS);
    cur_phase  = phase_q[idx];
    cur_cycles = cycles_q[idx];
    cur_dir    = dir_q[idx];
    cur_goal   = goal_q[idx];
    cur_status = status_q[idx];

    act        = run_q && (required_i != cur_status);
    start      = act && (cur_status != busy_q);
    fixed_code = (required_i == open_q) || (required_i == close_q);

    if (fixed_code) begin
      start_cnt = (motor_i == short_motor_q) ? short_q : full_q;
      start_dir = (required_i == close_q) ? ~ccw_q : ccw_q;
    end else if (required_i > cur_status) begin
      start_cnt = required_i - cur_status;
      start_dir = ccw_q;
    end else begin
      start_cnt = cur_status - required_i;
      start_dir = ~ccw_q;
    end

    step_cnt = start ? start_cnt  : cur_cycles;
    dir_d    = start ? start_dir  : cur_dir;
    goal_d   = start ? required_i : cur_goal;
    moving   = (step_cnt != '0);
    phase_d  = dir_d ? (cur_phase + PW'(1)) : (cur_phase - PW'(1));

    if (moving) begin
      cycles_d  = (phase_d == '0) ? (step_cnt - POSITION_BITS'(1)) : step_cnt;
      status_d  = busy_q;
      phase_res = phase_d;
    end else begin
      cycles_d  = step_cnt;
      status_d  = goal_d;
      phase_res = cur_phase;
    end

    if (!in_range) begin
      coil_o    = '0;
      updated_o = 1'b0;
      status_o  = '0;
    end else if (act) begin
      coil_o    = hspos_pkg::coil_of(phase_res);
      updated_o = moving;
      status_o  = status_d;
    end else begin
      coil_o    = hspos_pkg::coil_of(cur_phase);
      updated_o = 1'b0;
      status_o  = cur_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        phase_q[i]  <= '0;
        cycles_q[i] <= '0;
        dir_q[i]    <= 1'b0;
        goal_q[i]   <= '0;
        status_q[i] <= '0;
      end
    end else if (fire_i && in_range && act) begin
      phase_q[idx]  <= phase_res;
      cycles_q[idx] <= cycles_d;
      dir_q[idx]    <= dir_d;
      goal_q[idx]   <= goal_d;
      status_q[idx] <= status_d;
    end
  end

endmodule

/* sv/half_step_stepper_positioner_unit.sv */
// Half-step stepper positioner: one tick request in, one coil/status result out.
// A request is held in the request register and its result is registered once the result register
// can advance; one request is taken every cycle, limited only by the result channel's ready.
// Each tick reads and writes its motor's state between the request and result registers.
// Asynchronous active-low reset clears all motor state, empties both registers
// and loads the configuration defaults. Depends on hspos_pkg, the interfaces and hspos_core.
module half_step_stepper_positioner_unit #(
  parameter int NUM_MOTORS    = hspos_pkg::NUM_MOTORS_DEF,
  parameter int POSITION_BITS = hspos_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hspos_in_if.sink                          in_i,
  hspos_out_if.source                       out_o,
  input  logic                              cfg_we_i,
  input  logic [hspos_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [POSITION_BITS-1:0]          cfg_data_i
);

  logic                           in_vld_q;
  logic [hspos_pkg::MOTOR_W-1:0]  motor_q;
  logic [POSITION_BITS-1:0]       req_q;

  logic                           out_vld_q;
  logic [hspos_pkg::MOTOR_W-1:0]  served_q;
  logic [hspos_pkg::COIL_W-1:0]   coil_q;
  logic                           upd_q;
  logic [POSITION_BITS-1:0]       status_q;

  logic                           adv, fire, in_acc;
  logic [hspos_pkg::COIL_W-1:0]   coil_d;
  logic                           upd_d;
  logic [POSITION_BITS-1:0]       status_d;

  assign adv        = !out_vld_q || out_o.ready;
  assign fire       = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      motor_q <= in_i.motor_index;
      req_q   <= in_i.required_position;
    end
  end

  hspos_core #(
    .NUM_MOTORS    (NUM_MOTORS),
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .motor_i     (motor_q),
    .required_i  (req_q),
    .coil_o      (coil_d),
    .updated_o   (upd_d),
    .status_o    (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      served_q <= motor_q;
      coil_q   <= coil_d;
      upd_q    <= upd_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.motor_served      = served_q;
  assign out_o.coil_pattern      = coil_q;
  assign out_o.coils_updated     = upd_q;
  assign out_o.reported_position = status_q;

endmodule

/* sv/hspos_checker.sv */
// Port-level checker for the half-step stepper positioner, bound to the top level.
// Depends on hspos_pkg and half_step_stepper_positioner_unit.
module hspos_checker #(
  parameter int NUM_MOTORS    = hspos_pkg::NUM_MOTORS_DEF,
  parameter int POSITION_BITS = hspos_pkg::POSITION_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [hspos_pkg::MOTOR_W-1:0]  motor_served_i,
  input logic [hspos_pkg::COIL_W-1:0]   coil_pattern_i,
  input logic                           coils_updated_i,
  input logic [POSITION_BITS-1:0]       reported_position_i
);

  logic in_range;
  assign in_range = (int'(motor_served_i) < NUM_MOTORS);

  // A stalled result must keep its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(coil_pattern_i)
      && $stable(reported_position_i) && $stable(motor_served_i)
      && $stable(coils_updated_i))
    else $error("stalled result changed");

  // A result for a motor that does not exist has zero coil pattern, update flag and position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !in_range |-> coil_pattern_i == '0 && !coils_updated_i
      && reported_position_i == '0)
    else $error("out-of-range motor produced nonzero result");

  // A real motor always shows one of the eight half-step patterns.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_range |-> $countones(coil_pattern_i) == 1 || coil_pattern_i == 4'h3
      || coil_pattern_i == 4'h6 || coil_pattern_i == 4'hC || coil_pattern_i == 4'h9)
    else $error("illegal coil pattern");

  // No result can appear in the cycle after reset was seen.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid right after reset");

endmodule

bind half_step_stepper_positioner_unit hspos_checker #(
  .NUM_MOTORS    (NUM_MOTORS),
  .POSITION_BITS (POSITION_BITS)
) u_hspos_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .motor_served_i      (out_o.motor_served),
  .coil_pattern_i      (out_o.coil_pattern),
  .coils_updated_i     (out_o.coils_updated),
  .reported_position_i (out_o.reported_position)
);

/* tb/half_step_stepper_positioner_unit_test.sv */
`timescale 1ns / 100ps
// Testbench for half_step_stepper_positioner_unit: directed and random ticks with
// random idling on both channels, checked against an in-bench motor state tracker.
// Depends on hspos_pkg, hspos_in_if, hspos_out_if and the unit itself.
module half_step_stepper_positioner_unit_test;

  localparam int MOTORS       = hspos_pkg::NUM_MOTORS_DEF;
  localparam int POS_W        = hspos_pkg::POSITION_BITS_DEF;
  localparam int MOTOR_W      = hspos_pkg::MOTOR_W;
  localparam int COIL_W       = hspos_pkg::COIL_W;
  localparam int PHASE_W      = hspos_pkg::PHASE_W;
  localparam int POS_MAX      = (1 << POS_W) - 1;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [COIL_W-1:0] COIL_SEQ [8] = '{4'h1, 4'h3, 4'h2, 4'h6,
                                                 4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic [COIL_W-1:0]  coil;
    logic               updated;
    logic [POS_W-1:0]   position;
  } coil_report_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [hspos_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [POS_W-1:0]                cfg_data;

  hspos_in_if  #(.POSITION_BITS(POS_W)) tick_if ();
  hspos_out_if #(.POSITION_BITS(POS_W)) coil_if ();

  half_step_stepper_positioner_unit #(
    .NUM_MOTORS   (MOTORS),
    .POSITION_BITS(POS_W)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (coil_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  logic [POS_W-1:0]   open_code, close_code, busy_code, full_travel, short_travel;
  logic [MOTOR_W-1:0] short_motor;
  logic               ccw_value, run_enable;

  logic [PHASE_W-1:0] phase_q  [MOTORS];
  logic [POS_W-1:0]   cycles_q [MOTORS];
  logic               dir_q    [MOTORS];
  logic [POS_W-1:0]   goal_q   [MOTORS];
  logic [POS_W-1:0]   status_q [MOTORS];

  coil_report_t pending_reports[$];
  int err_count = 0;
  int ticks_sent = 0;
  int reports_seen = 0;
  int settings_used = 0;
  int quiet_cycles = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_request = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_motor_model();
    open_code    = POS_W'(hspos_pkg::OPEN_CODE_RST);
    close_code   = POS_W'(hspos_pkg::CLOSE_CODE_RST);
    busy_code    = POS_W'(hspos_pkg::BUSY_CODE_RST);
    full_travel  = POS_W'(hspos_pkg::FULL_TRAVEL_RST);
    short_travel = POS_W'(hspos_pkg::SHORT_TRAVEL_RST);
    short_motor  = hspos_pkg::SHORT_MOTOR_RST;
    ccw_value    = hspos_pkg::CCW_VALUE_RST;
    run_enable   = hspos_pkg::RUN_ENABLE_RST;
    for (int i = 0; i < MOTORS; i++) begin
      phase_q[i]  = '0;
      cycles_q[i] = '0;
      dir_q[i]    = 1'b0;
      goal_q[i]   = '0;
      status_q[i] = '0;
    end
  endfunction

  function automatic coil_report_t advance_motor(input logic [MOTOR_W-1:0] m,
                                                 input logic [POS_W-1:0] req);
    coil_report_t r;
    int diff;
    logic cw;
    r = '0;
    r.motor = m;
    if (m >= MOTORS) return r;
    if (run_enable && req != status_q[m]) begin
      if (status_q[m] != busy_code) begin
        cw = ~ccw_value;
        if (req == open_code || req == close_code) begin
          cycles_q[m] = (m == short_motor) ? short_travel : full_travel;
          dir_q[m] = (req == close_code) ? cw : ccw_value;
        end else begin
          diff = int'(req) - int'(status_q[m]);
          dir_q[m] = (diff > 0) ? ccw_value : cw;
          cycles_q[m] = POS_W'((diff > 0) ? diff : -diff);
        end
        goal_q[m] = req;
      end
      if (cycles_q[m] != 0) begin
        phase_q[m] = dir_q[m] ? phase_q[m] + 1'b1 : phase_q[m] - 1'b1;
        if (phase_q[m] == 0) cycles_q[m] = cycles_q[m] - 1'b1;
        status_q[m] = busy_code;
        r.updated = 1'b1;
      end else begin
        status_q[m] = goal_q[m];
      end
    end
    r.coil = COIL_SEQ[phase_q[m]];
    r.position = status_q[m];
    return r;
  endfunction

  function automatic int random_span();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_tick(input logic [MOTOR_W-1:0] m, input logic [POS_W-1:0] req);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? random_span() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      tick_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    tick_if.valid <= 1'b1;
    tick_if.motor_index <= m;
    tick_if.required_position <= req;
    do @(posedge clk_i); while (!tick_if.ready);
    pending_reports.push_back(advance_motor(m, req));
    ticks_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    tick_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input hspos_pkg::cfg_reg_e idx, input int value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= POS_W'(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      hspos_pkg::CFG_OPEN_CODE:    open_code = POS_W'(value);
      hspos_pkg::CFG_CLOSE_CODE:   close_code = POS_W'(value);
      hspos_pkg::CFG_BUSY_CODE:    busy_code = POS_W'(value);
      hspos_pkg::CFG_FULL_TRAVEL:  full_travel = POS_W'(value);
      hspos_pkg::CFG_SHORT_TRAVEL: short_travel = POS_W'(value);
      hspos_pkg::CFG_SHORT_MOTOR:  short_motor = MOTOR_W'(value);
      hspos_pkg::CFG_CCW_VALUE:    ccw_value = value[0];
      default:                     run_enable = value[0];
    endcase
  endtask

  task automatic apply_settings(input int open_c, input int close_c, input int busy_c,
                                input int full_t, input int short_t, input int short_m,
                                input int ccw, input int run);
    settle();
    write_reg(hspos_pkg::CFG_OPEN_CODE, open_c);
    write_reg(hspos_pkg::CFG_CLOSE_CODE, close_c);
    write_reg(hspos_pkg::CFG_BUSY_CODE, busy_c);
    write_reg(hspos_pkg::CFG_FULL_TRAVEL, full_t);
    write_reg(hspos_pkg::CFG_SHORT_TRAVEL, short_t);
    write_reg(hspos_pkg::CFG_SHORT_MOTOR, short_m);
    write_reg(hspos_pkg::CFG_CCW_VALUE, ccw);
    write_reg(hspos_pkg::CFG_RUN_ENABLE, run);
    settings_used++;
  endtask

  // Moving motors mostly keep their goal so that moves run to completion;
  // idle motors get short moves, open or close requests, or repeats.
  task automatic random_tick();
    logic [MOTOR_W-1:0] m;
    logic [POS_W-1:0] req;
    int r;
    int target;
    r = $urandom_range(0, 99);
    m = ($urandom_range(0, 11) == 0) ? MOTOR_W'(MOTORS)
                                     : MOTOR_W'($urandom_range(0, MOTORS - 1));
    if (m >= MOTORS) begin
      req = POS_W'($urandom);
    end else if (status_q[m] == busy_code) begin
      if (r < 80) req = goal_q[m];
      else if (r < 88) req = busy_code;
      else req = POS_W'($urandom);
    end else if (r < 8) begin
      req = status_q[m];
    end else if (r < 16) begin
      req = open_code;
    end else if (r < 24) begin
      req = close_code;
    end else begin
      target = int'(status_q[m]) + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 6);
      if (target < 0) target = 0;
      if (target > POS_MAX) target = POS_MAX;
      req = POS_W'(target);
    end
    send_tick(m, req);
  endtask

  task automatic run_phase(input int open_c, input int close_c, input int busy_c,
                           input int full_t, input int short_t, input int short_m,
                           input int ccw, input int run, input int count,
                           input bit gaps, input bit stalls);
    apply_settings(open_c, close_c, busy_c, full_t, short_t, short_m, ccw, run);
    gaps_on = gaps;
    stalls_on = stalls;
    repeat (count) random_tick();
  endtask

  task automatic test_directed_ticks();
    settle();
    write_reg(hspos_pkg::CFG_FULL_TRAVEL, 1);
    write_reg(hspos_pkg::CFG_SHORT_TRAVEL, 1);
    write_reg(hspos_pkg::CFG_BUSY_CODE, 1);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_tick(MOTOR_W'(0), POS_W'(0));
    send_tick(MOTOR_W'(MOTORS), POS_W'(POS_MAX));
    repeat (10) send_tick(MOTOR_W'(0), POS_W'(1));
    send_tick(MOTOR_W'(0), POS_W'(0));
    repeat (2) send_tick(MOTOR_W'(1), close_code);
    send_tick(MOTOR_W'(1), busy_code);
    send_tick(MOTOR_W'(2), open_code);
  endtask

  task automatic test_zero_travel();
    settle();
    write_reg(hspos_pkg::CFG_BUSY_CODE, hspos_pkg::BUSY_CODE_RST);
    write_reg(hspos_pkg::CFG_FULL_TRAVEL, 0);
    write_reg(hspos_pkg::CFG_SHORT_TRAVEL, 0);
    send_tick(MOTOR_W'(0), open_code);
    send_tick(MOTOR_W'(1), close_code);
    send_tick(MOTOR_W'(2), open_code);
  endtask

  task automatic test_run_disabled();
    settle();
    write_reg(hspos_pkg::CFG_RUN_ENABLE, 0);
    send_tick(MOTOR_W'(0), POS_W'(7));
    send_tick(MOTOR_W'(1), POS_W'(POS_MAX));
    send_tick(MOTOR_W'(MOTORS), POS_W'(0));
    settle();
    write_reg(hspos_pkg::CFG_RUN_ENABLE, 1);
  endtask

  task automatic test_short_motor_out_of_range();
    settle();
    write_reg(hspos_pkg::CFG_SHORT_MOTOR, 3);
    write_reg(hspos_pkg::CFG_FULL_TRAVEL, 2);
    write_reg(hspos_pkg::CFG_SHORT_TRAVEL, 1);
    repeat (2) send_tick(MOTOR_W'(2), close_code);
  endtask

  task automatic test_random_traffic();
    run_phase(1021, 1022, 1023, 3, 1, 2, 1, 1, 250, 1'b1, 1'b1);
    run_phase(0, 1023, 1000, 1, 2, 0, 0, 1, 250, 1'b0, 1'b0);
    run_phase(500, 501, 0, 2, 4, 1, 1, 1, 250, 1'b1, 1'b1);
    run_phase(1021, 1022, 1023, 1, 1, 3, 0, 1, 250, 1'b1, 1'b0);
    run_phase(1021, 1022, 1023, 2, 3, 2, 1, 0, 60, 1'b1, 1'b1);
  endtask

  task automatic test_backpressure();
    run_phase(1021, 1022, 1023, 4, 2, 1, 1, 1, 40, 1'b0, 1'b0);
    hold_request = 1'b1;
    repeat (60) random_tick();
    stalls_on = 1'b1;
    repeat (200) random_tick();
  endtask

  task automatic test_long_travel();
    apply_settings(1021, 1022, 1023, 1023, 1023, 0, 1, 1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    for (int m = 0; m < MOTORS; m++) begin
      repeat (20) send_tick(MOTOR_W'(m), (status_q[m] == open_code) ? close_code : open_code);
    end
  endtask

  initial begin
    coil_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        coil_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        coil_if.ready <= 1'b0;
        repeat (random_span() - 1) @(negedge clk_i);
      end else begin
        coil_if.ready <= 1'b1;
      end
    end
  end

  task automatic note_error(input string what, input coil_report_t want,
                            input coil_report_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t %s: want motor %0d coil %h upd %0b pos %0d,",
               $realtime, what, want.motor, want.coil, want.updated, want.position);
      $display("    got motor %0d coil %h upd %0b pos %0d",
               got.motor, got.coil, got.updated, got.position);
    end
  endtask

  always @(posedge clk_i) begin
    coil_report_t got;
    coil_report_t want;
    if (rst_ni && coil_if.valid && coil_if.ready) begin
      got.motor = coil_if.motor_served;
      got.coil = coil_if.coil_pattern;
      got.updated = coil_if.coils_updated;
      got.position = coil_if.reported_position;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        note_error("unexpected result", 'x, got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) note_error("mismatch", want, got);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (coil_if.valid && coil_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = hspos_pkg::CFG_OPEN_CODE;
    cfg_data = '0;
    tick_if.valid = 1'b0;
    tick_if.motor_index = '0;
    tick_if.required_position = '0;
    reset_motor_model();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ticks();
    test_zero_travel();
    test_run_disabled();
    test_short_motor_out_of_range();
    test_random_traffic();
    test_backpressure();
    test_long_travel();
    settle();
    repeat (10) @(posedge clk_i);

    if (pending_reports.size() != 0) begin
      err_count += pending_reports.size();
      $display("%0d expected results never arrived", pending_reports.size());
    end
    $display("Ran %0d motor ticks under %0d register settings with idling and a long hold-off,",
             ticks_sent, settings_used);
    $display("checked %0d results and found %0d errors.", reports_seen, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
